// File: hdl/pfx_pkg.sv
// shared types, constants and codes of the postfix expression evaluator
package pfx_pkg;

  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int STATUS_W    = 3;
  localparam int OUT_DATA_W  = ((DATA_W + STATUS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - DATA_W - STATUS_W;

  // character codes
  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_POW  = 8'h5E;
  localparam logic [SYM_W-1:0] SYM_LPAR = 8'h28;
  localparam logic [SYM_W-1:0] SYM_RPAR = 8'h29;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_UNDERFLOW   = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_DIVZERO     = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } pfx_status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } pfx_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RHS,
    S_POP_LHS,
    S_CAP_LHS,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_REPORT_RD,
    S_REPORT
  } pfx_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic cap_rhs;
    logic cap_lhs;
    logic exec;
    logic div_start;
    logic div_take;
    logic push;
    logic rd_top;
    logic report;
  } pfx_cmd_t;

  // datapath to controller
  typedef struct packed {
    pfx_op_t new_op;
    pfx_op_t op;
    logic    last;
    logic    rhs_zero;
    logic    div_done;
    logic    out_free;
  } pfx_sts_t;

endpackage

// File: hdl/postfix_expression_evaluator_top.sv
// top level of the postfix expression evaluator
//
// channel | direction | tdata fields (lsb up)                  | tuser | tlast
// in_     | slave     | symbol[7:0]                            | -     | last character
// out_    | master    | value[31:0], status[34:32], zeros[39:35] | -     | -
//
// one character at a time; an operand goes through push, + - * and unsupported through
// two pops, lhs capture, exec and push; / with a nonzero divisor also waits on the 32-step
// restoring divider; a character marked last adds a read of the top of the stack and a report
// reset: rst_n synchronous active low, empties the stack and clears the status
// the result register lets the next character in while a result waits; a character
// marked last holds in its report step until the result register is free
module postfix_expression_evaluator_top
  import pfx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SYM_W-1:0]      in_tdata,   // symbol[7:0]
  input  logic                  in_tlast,
  // result transactions
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // value[31:0], status[34:32], zero pad
);

  pfx_cmd_t    cmd;
  pfx_sts_t    sts;
  logic [DATA_W-1:0] out_value;
  pfx_status_t out_status;

  // sequencing of one character
  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stack, alu, divider and result register
  pfx_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_value};

endmodule

// File: hdl/pfx_div.sv
// signed 32-bit divider, restoring, one quotient bit per cycle, truncates toward zero
module pfx_div
  import pfx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic [DATA_W:0]    rem_r;
  logic [DATA_W-1:0]  quo_r;
  logic [DATA_W-1:0]  dvs_r;
  logic               neg_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [DATA_W:0]    rem_sh;
  logic [DATA_W:0]    diff;

  assign rem_sh = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  // magnitudes at start, then shift-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      dvs_r <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff;
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DATA_W'(1)) : quo_r;

endmodule

// File: hdl/pfx_dp.sv
// datapath: operand stack memory, stack count, sticky status, alu, divider, result register
module pfx_dp
  import pfx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pfx_cmd_t          cmd,
  output pfx_sts_t          sts,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output pfx_status_t       out_status
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  pfx_status_t       err_r, err_nxt;
  logic              empty_r, empty_nxt;
  logic              last_r;
  pfx_op_t           op_r;
  pfx_op_t           dec_op;
  logic [SYM_W-1:0]  sym_r;
  logic [DATA_W-1:0] rhs_r, rhs_nxt;
  logic [DATA_W-1:0] lhs_r, lhs_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  pfx_status_t       out_status_r, out_status_nxt;

  logic [CNT_W-1:0]  top_idx;
  logic              rd_en;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] product;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  assign top_idx = count_r - CNT_W'(1);
  assign product = lhs_r * rhs_r;

  always_comb begin
    unique case (in_symbol) inside
      SYM_ADD:                    dec_op = OP_ADD;
      SYM_SUB:                    dec_op = OP_SUB;
      SYM_MUL:                    dec_op = OP_MUL;
      SYM_DIV:                    dec_op = OP_DIV;
      SYM_POW, SYM_LPAR, SYM_RPAR: dec_op = OP_BAD;
      default:                    dec_op = OP_PUSH;
    endcase
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    count_nxt      = count_r;
    err_nxt        = err_r;
    empty_nxt      = empty_r;
    rhs_nxt        = rhs_r;
    lhs_nxt        = lhs_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = (op_r == OP_PUSH) ? ({{(DATA_W-SYM_W){1'b0}}, sym_r} -
                                          {{(DATA_W-SYM_W){1'b0}}, SYM_ZERO})
                                       : res_r;

    if (cmd.pop) begin
      if (count_r == '0) begin
        empty_nxt = 1'b1;
        if (err_r == ST_OK) err_nxt = ST_UNDERFLOW;
      end else begin
        empty_nxt = 1'b0;
        rd_en     = 1'b1;
        count_nxt = top_idx;
      end
    end

    // an empty pop reads as all ones
    if (cmd.cap_rhs) rhs_nxt = empty_r ? '1 : rd_data_r;
    if (cmd.cap_lhs) lhs_nxt = empty_r ? '1 : rd_data_r;

    if (cmd.exec) begin
      case (op_r)
        OP_ADD: res_nxt = lhs_r + rhs_r;
        OP_SUB: res_nxt = lhs_r - rhs_r;
        OP_MUL: res_nxt = product;
        OP_DIV: begin
          res_nxt = '0;
          if (rhs_r == '0 && err_r == ST_OK) err_nxt = ST_DIVZERO;
        end
        OP_BAD: begin
          res_nxt = '0;
          if (err_r == ST_OK) err_nxt = ST_UNSUPPORTED;
        end
        default: res_nxt = res_r;
      endcase
    end

    if (cmd.div_take) res_nxt = div_quo;

    if (cmd.push) begin
      if (count_r >= CNT_W'(STACK_DEPTH)) begin
        if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.rd_top) rd_en = (count_r != '0);

    if (cmd.report) begin
      out_valid_nxt = 1'b1;
      if (count_r == '0) begin
        out_value_nxt  = '0;
        out_status_nxt = (err_r == ST_OK) ? ST_UNDERFLOW : err_r;
      end else begin
        out_value_nxt  = rd_data_r;
        out_status_nxt = err_r;
      end
      count_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= ST_OK;
      empty_r     <= 1'b0;
      last_r      <= 1'b0;
      op_r        <= OP_PUSH;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.accept) begin
        last_r <= in_last;
        op_r   <= dec_op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) sym_r <= in_symbol;
    rhs_r        <= rhs_nxt;
    lhs_r        <= lhs_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[PTR_W-1:0]] <= wr_data;
    if (rd_en) rd_data_r <= mem[top_idx[PTR_W-1:0]];
  end

  assign sts.new_op   = dec_op;
  assign sts.op       = op_r;
  assign sts.last     = last_r;
  assign sts.rhs_zero = (rhs_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/pfx_ctrl.sv
// controller: sequences pops, alu work, division, push and report per character
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfx_sts_t sts,
  output pfx_cmd_t cmd
);

  pfx_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = (sts.new_op == OP_PUSH) ? S_PUSH : S_POP_RHS;
      end
      S_POP_RHS: state_nxt = S_POP_LHS;
      S_POP_LHS: state_nxt = S_CAP_LHS;
      S_CAP_LHS: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = (sts.op == OP_DIV && !sts.rhs_zero) ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_PUSH;
      end
      S_PUSH:      state_nxt = sts.last ? S_REPORT_RD : S_IDLE;
      S_REPORT_RD: state_nxt = S_REPORT;
      S_REPORT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_POP_RHS: cmd.pop = 1'b1;
      S_POP_LHS: begin
        cmd.cap_rhs = 1'b1;
        cmd.pop     = 1'b1;
      end
      S_CAP_LHS: cmd.cap_lhs = 1'b1;
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = (sts.op == OP_DIV) && !sts.rhs_zero;
      end
      S_DIV:       cmd.div_take = sts.div_done;
      S_PUSH:      cmd.push = 1'b1;
      S_REPORT_RD: cmd.rd_top = 1'b1;
      S_REPORT:    cmd.report = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: hdl/pfx_checker.sv
// port-level checker for the postfix expression evaluator, bound to the top level
module pfx_checker
  import pfx_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one character in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  // a new result appears as the block returns to accepting characters
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised outside the report step");

  // status is a defined code and the padding is zero
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_W+STATUS_W-1:DATA_W] <= ST_UNSUPPORTED) &&
                   (out_tdata[OUT_DATA_W-1:DATA_W+STATUS_W] == '0))
    else $error("bad status code or padding");

endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/tb.sv
// self-checking stream testbench for the postfix expression evaluator
module tb;
  import pfx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_N       = 30;      // rows in the directed table
  localparam int RAND_ITEMS  = 1200;    // characters in the random part
  localparam int CALM_ITEMS  = 150;     // final characters sent with no idling
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int DRAIN_WAIT  = 64;      // settle time after the last result
  localparam int CYCLE_LIMIT = 400000;  // run limit in clock cycles

  // one expected result: the value on top of the stack and the sticky status
  typedef struct packed {
    logic [DATA_W-1:0] value;
    pfx_status_t       status;
  } rpn_result_t;

  // a directed character, with a typed result where it is obvious
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] value;
    pfx_status_t       status;
  } dir_row_t;

  // builds 2^31 from 128^4 * 8, then divides it by 0 - 1
  localparam logic [SYM_W-1:0] MIN_DIV_SEQ [13] = '{
    8'hB0, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, SYM_ZERO + 8'd8, SYM_MUL,
    SYM_ZERO, SYM_ZERO + 8'd1, SYM_SUB, SYM_DIV
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SYM_W-1:0]      in_tdata;   // symbol[7:0]
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // value[31:0], status[34:32], zero pad

  // shadow copy of the operand stack and the sticky status
  logic [DATA_W-1:0] stk_mirror [STACK_DEPTH];
  int unsigned       stk_fill  = 0;
  pfx_status_t       sticky_st = ST_OK;

  // results still owed by the block, oldest first
  rpn_result_t expected_results[$];

  // typed result for the character on the bus, set when it is driven
  logic        fixed_on = 1'b0;
  rpn_result_t fixed_res;

  dir_row_t dir_tbl [DIR_N];
  int       items_sent    = 0;
  int       cycle_no      = 0;
  bit       mismatch_seen = 1'b0;
  bit       calm          = 1'b0;  // no idling on either side
  bit       tx_gappy      = 1'b0;
  bit       rx_gappy      = 1'b1;
  bit       hold_req      = 1'b0;
  bit       hold_done     = 1'b0;

  postfix_expression_evaluator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  function automatic bit is_operator(logic [SYM_W-1:0] s);
    return s inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_POW, SYM_LPAR, SYM_RPAR};
  endfunction

  // first error of an expression wins
  function automatic void note_error(pfx_status_t code);
    if (sticky_st == ST_OK) begin
      sticky_st = code;
    end
  endfunction

  // a push onto a full stack is dropped
  function automatic void push_operand(logic [DATA_W-1:0] v);
    if (stk_fill >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
    end else begin
      stk_mirror[stk_fill] = v;
      stk_fill++;
    end
  endfunction

  // a pop from an empty stack reads all ones
  function automatic logic [DATA_W-1:0] pop_operand();
    if (stk_fill == 0) begin
      note_error(ST_UNDERFLOW);
      return '1;
    end
    stk_fill--;
    return stk_mirror[stk_fill];
  endfunction

  // applies one character; returns 1 with the result when the character ends an expression
  function automatic bit eval_symbol(input logic [SYM_W-1:0] sym, input logic last,
                                     output rpn_result_t res);
    logic [DATA_W-1:0] rhs, lhs, acc, mag_l, mag_r, quo;
    acc = '0;
    res = '0;
    if (is_operator(sym)) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (sym)
        SYM_ADD: acc = lhs + rhs;
        SYM_SUB: acc = lhs - rhs;
        SYM_MUL: acc = lhs * rhs;
        SYM_DIV: begin
          if (rhs == '0) begin
            note_error(ST_DIVZERO);
          end else begin
            // divide magnitudes, truncating toward zero; min / -1 wraps back to min
            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
            quo   = mag_l / mag_r;
            acc   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
          end
        end
        default: note_error(ST_UNSUPPORTED);
      endcase
      push_operand(acc);
    end else begin
      push_operand(DATA_W'(sym) - DATA_W'(SYM_ZERO));
    end
    if (!last) begin
      return 1'b0;
    end
    if (stk_fill == 0) begin
      note_error(ST_UNDERFLOW);
    end else begin
      res.value = stk_mirror[stk_fill-1];
    end
    res.status = sticky_st;
    stk_fill   = 0;
    sticky_st  = ST_OK;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // clock, cycle limit
  // ------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // a hang anywhere ends the run as a failure
  initial begin
    while (cycle_no < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_no++;
    end
    $display("[postfix_expression_evaluator_top] ERROR");
    $finish;
  end

  // ------------------------------------------------------------------
  // monitor: checks results, then predicts from accepted characters
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    rpn_result_t want, nxt;
    if (rst_n) begin
      // a result leaving this edge belongs to an earlier character, so check it first
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none pending, got value %h status %0d", $time,
                   out_tdata[DATA_W-1:0], out_tdata[DATA_W +: STATUS_W]);
          mismatch_seen = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want.value,
                     out_tdata[DATA_W-1:0]);
            mismatch_seen = 1'b1;
          end
          if (out_tdata[DATA_W +: STATUS_W] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                     out_tdata[DATA_W +: STATUS_W]);
            mismatch_seen = 1'b1;
          end
          if (out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
            $display("%0t: pad mismatch, expected 0, got %h", $time,
                     out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
            mismatch_seen = 1'b1;
          end
        end
      end
      // the predictor always runs; a typed directed result replaces its answer
      if (in_tvalid && in_tready) begin
        if (eval_symbol(in_tdata, in_tlast, nxt)) begin
          if (fixed_on) begin
            nxt = fixed_res;
          end
          expected_results.push_back(nxt);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off, none when calm
  // ------------------------------------------------------------------

  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the result register fills and the input backs up
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        // switch between stretches with and without stalls
        if ($urandom_range(0, 63) == 0) begin
          rx_gappy = !rx_gappy;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // sender
  // ------------------------------------------------------------------

  // offers one character and returns at the edge that accepts it;
  // tvalid stays high between back-to-back transactions
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last,
                             input logic use_fixed, input logic [DATA_W-1:0] fix_value,
                             input pfx_status_t fix_status);
    int gap;
    @(negedge clk);
    if (items_sent % 48 == 0) begin
      tx_gappy = ($urandom_range(0, 1) == 1);
    end
    if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // the monitor reads these only at the accepting edge of this character
    fixed_on         = use_fixed;
    fixed_res.value  = fix_value;
    fixed_res.status = fix_status;
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  function automatic logic [SYM_W-1:0] pick_operand();
    logic [SYM_W-1:0] s;
    // mostly decimal digits, sometimes any non-operator byte
    if ($urandom_range(0, 3) != 0) begin
      return SYM_ZERO + SYM_W'($urandom_range(0, 9));
    end
    s = SYM_W'($urandom_range(0, 255));
    while (is_operator(s)) s = SYM_W'($urandom_range(0, 255));
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] pick_operator();
    case ($urandom_range(0, 12))
      0, 1, 2:  return SYM_ADD;
      3, 4, 5:  return SYM_SUB;
      6, 7, 8:  return SYM_MUL;
      9, 10:    return SYM_DIV;
      11:       return SYM_POW;
      default:  return $urandom_range(0, 1) ? SYM_LPAR : SYM_RPAR;
    endcase
  endfunction

  // one random expression: mostly well-formed, some deep enough to overflow, some with a
  // character dropped or an operator slipped in, some pure noise, some the min / -1 sequence
  task automatic send_expression();
    logic [SYM_W-1:0] expr[$];
    int kind, n_opnd, depth, pos;
    bit push_first;
    kind = $urandom_range(0, 19);
    if (kind >= 14 && kind <= 16) begin
      repeat ($urandom_range(1, 8)) expr.push_back(SYM_W'($urandom_range(0, 255)));
    end else if (kind == 19) begin
      foreach (MIN_DIV_SEQ[i]) expr.push_back(MIN_DIV_SEQ[i]);
    end else begin
      push_first = (kind == 12 || kind == 13);
      n_opnd     = push_first ? $urandom_range(14, 20) : $urandom_range(1, 9);
      depth      = 0;
      // keep the postfix form valid: an operator needs two operands below it
      while (n_opnd > 0 || depth > 1) begin
        if (depth < 2 || (n_opnd > 0 && (push_first || $urandom_range(0, 1)))) begin
          expr.push_back(pick_operand());
          n_opnd--;
          depth++;
        end else begin
          expr.push_back(pick_operator());
          depth--;
        end
      end
      if (kind >= 17) begin
        pos = $urandom_range(0, expr.size() - 1);
        if ($urandom_range(0, 1)) begin
          expr.delete(pos);
        end else begin
          expr.insert(pos, pick_operator());
        end
        if (expr.size() == 0) begin
          expr.push_back(pick_operand());
        end
      end
    end
    foreach (expr[i]) send_symbol(expr[i], i == expr.size() - 1, 1'b0, '0, ST_OK);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;

    // directed characters; typed results where the answer is plain
    dir_tbl = '{
      // single zero digit
      '{SYM_ZERO,        1'b1, 1'b1, 32'd0,          ST_OK},
      // highest and lowest character codes are plain operands
      '{8'hFF,           1'b1, 1'b1, 32'd207,        ST_OK},
      '{8'h00,           1'b1, 1'b1, 32'hFFFF_FFD0,  ST_OK},
      // add on an empty stack: both pops read all ones
      '{SYM_ADD,         1'b1, 1'b1, 32'hFFFF_FFFE,  ST_UNDERFLOW},
      // 7 3 - 9 *
      '{SYM_ZERO + 8'd7, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO + 8'd3, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_SUB,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO + 8'd9, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_MUL,         1'b1, 1'b0, 32'd0,          ST_OK},
      // divide by zero pushes zero
      '{SYM_ZERO + 8'd5, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO,        1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_DIV,         1'b1, 1'b1, 32'd0,          ST_DIVZERO},
      // caret is not supported
      '{SYM_ZERO + 8'd3, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO + 8'd4, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_POW,         1'b1, 1'b1, 32'd0,          ST_UNSUPPORTED},
      // parentheses on an empty stack: underflow comes first and sticks
      '{SYM_LPAR,        1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_RPAR,        1'b1, 1'b1, 32'd0,          ST_UNDERFLOW},
      // most negative value divided by minus one wraps without error
      '{8'hB0,           1'b0, 1'b0, 32'd0,          ST_OK},
      '{8'hB0,           1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_MUL,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{8'hB0,           1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_MUL,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{8'hB0,           1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_MUL,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO + 8'd8, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_MUL,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO,        1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_ZERO + 8'd1, 1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_SUB,         1'b0, 1'b0, 32'd0,          ST_OK},
      '{SYM_DIV,         1'b1, 1'b1, 32'h8000_0000,  ST_OK}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      send_symbol(dir_tbl[i].sym, dir_tbl[i].last, dir_tbl[i].typed,
                  dir_tbl[i].value, dir_tbl[i].status);
    end

    // random expressions, with one long receiver hold-off early on
    while (items_sent < DIR_N + RAND_ITEMS) begin
      if (!hold_done && items_sent >= DIR_N + 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent >= DIR_N + RAND_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      send_expression();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain: the cycle limit catches a result that never comes
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (!mismatch_seen && expected_results.size() == 0) begin
      $display("[postfix_expression_evaluator_top] OK");
    end else begin
      $display("[postfix_expression_evaluator_top] ERROR");
    end
    $finish;
  end

endmodule
